>>> hdl/bvc_pkg.sv
// Shared types and constants for the boxed value compare block.
`timescale 1ns / 1ps
package bvc_pkg;
	localparam logic [63:0] QNAN_PREFIX = 64'h7FF8000000000000;
	localparam logic [63:0] NULL_WORD = 64'h7FFB000000000000;
	localparam logic [63:0] BOOL_FALSE_WORD = 64'h7FFA000000000000;
	localparam logic [2:0] TAG_INT48 = 3'd1;
	localparam logic [2:0] TAG_BOOL = 3'd2;

	localparam logic [2:0] OP_EQ = 3'd0;
	localparam logic [2:0] OP_NEQ = 3'd1;
	localparam logic [2:0] OP_LT = 3'd2;
	localparam logic [2:0] OP_LTE = 3'd3;
	localparam logic [2:0] OP_GT = 3'd4;
	localparam logic [2:0] OP_GTE = 3'd5;
	localparam logic [2:0] OP_TRUTHY = 3'd6;
	localparam logic [2:0] OP_UNUSED = 3'd7;

	// classified operand: sortable magnitude key for a non-NaN value
	typedef struct packed {
		logic        nan;
		logic        zero;
		logic        neg;
		logic [62:0] mag;
	} bvc_val_t;

	typedef struct packed {
		logic [2:0] op;
		logic       same;
		logic       truth;
		bvc_val_t   lv;
		bvc_val_t   rv;
	} bvc_item_t;
endpackage

>>> hdl/boxed_value_compare_top.sv
// Top level of the boxed value compare block.
`timescale 1ns / 1ps
// Compares two NaN-boxed words (eq, neq, lt, lte, gt, gte) or tests the left
// word for truthiness, one result beat per request beat. Accepts one request
// per cycle while full is low; each request passes the decode register, the
// two-entry queue and the compare register, and both sides may stall freely.
module boxed_value_compare_top import bvc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  req_type,
	input  logic [63:0] left_word,
	input  logic [63:0] right_word,
	output logic        empty,
	input  logic        pop,
	output logic        result_bit,
	output logic [63:0] result_word
);
	logic      f_valid, f_ready, q_valid, q_ready, b_ready, b_valid;
	bvc_item_t f_item, q_item;

	bvc_front u_front (.clk, .arst_n, .in_valid(push), .in_ready(b_ready),
		.req_type, .left_word, .right_word,
		.out_valid(f_valid), .out_ready(f_ready), .out_item(f_item));

	bvc_queue u_queue (.clk, .arst_n, .in_valid(f_valid), .in_ready(f_ready),
		.in_item(f_item), .out_valid(q_valid), .out_ready(q_ready),
		.out_item(q_item));

	bvc_back u_back (.clk, .arst_n, .in_valid(q_valid), .in_ready(q_ready),
		.in_item(q_item), .out_valid(b_valid), .out_ready(pop),
		.result_bit);

	assign full = !b_ready;
	assign empty = !b_valid;
	assign result_word = {BOOL_FALSE_WORD[63:1], result_bit};
endmodule

>>> hdl/bvc_front.sv
// Front stage: decodes both boxed words into sign/magnitude keys.
`timescale 1ns / 1ps
module bvc_front import bvc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [63:0] left_word,
	input  logic [63:0] right_word,
	output logic        out_valid,
	input  logic        out_ready,
	output bvc_item_t   out_item
);
	logic      valid_s1;
	bvc_item_t item_s1;
	bvc_item_t item_d;

	function automatic bvc_val_t decode(input logic [63:0] w);
		bvc_val_t    v;
		logic [47:0] p;
		logic [47:0] a;
		logic [5:0]  lz;
		logic [47:0] sig;
		logic [10:0] ex;
		p = w[47:0];
		v = '0;
		if ((w & QNAN_PREFIX) != QNAN_PREFIX) begin
			v.nan = (w[62:52] == 11'h7FF) && (w[51:0] != '0);
			v.zero = (w[62:0] == '0);
			v.neg = w[63] && !v.zero;
			v.mag = w[62:0];
		end else if (w[50:48] == TAG_INT48) begin
			a = p[47] ? (~p + 48'd1) : p;
			// int48 fits exactly in a double; build its bit pattern
			lz = '0;
			for (int i = 0; i < 48; i++)
				if (a[i]) lz = 6'(47 - i);
			sig = a << lz;
			ex = 11'(1023 + 47) - 11'(lz);
			v.zero = (a == '0);
			v.neg = p[47];
			v.mag = v.zero ? '0 : {ex, sig[46:0], 5'd0};
		end else if (w[50:48] == TAG_BOOL) begin
			v.zero = (p == '0);
			v.mag = v.zero ? '0 : 63'h3FF0000000000000;
		end else begin
			v.nan = 1'b1;
		end
		return v;
	endfunction

	function automatic logic truthy(input logic [63:0] w);
		if (w == NULL_WORD) return 1'b0;
		if ((w & QNAN_PREFIX) != QNAN_PREFIX)
			return (w[62:0] != '0) &&
				!((w[62:52] == 11'h7FF) && (w[51:0] != '0));
		if (w[50:48] == TAG_INT48 || w[50:48] == TAG_BOOL)
			return w[47:0] != '0;
		return 1'b1;
	endfunction

	always_comb begin
		item_d.op = req_type;
		item_d.same = (left_word == right_word);
		item_d.truth = truthy(left_word);
		item_d.lv = decode(left_word);
		item_d.rv = decode(right_word);
	end

	assign in_ready = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (in_ready) valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_s1 <= item_d;
	end
endmodule

>>> hdl/bvc_queue.sv
// Two-entry queue between the decode front and the compare back.
`timescale 1ns / 1ps
module bvc_queue import bvc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  bvc_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output bvc_item_t out_item
);
	bvc_item_t mem_q [2];
	logic      wp_q, rp_q;
	logic [1:0] cnt_q;
	logic      wr, rd;

	assign in_ready = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_item = mem_q[rp_q];
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_item;
	end
endmodule

>>> hdl/bvc_back.sv
// Back stage: ordered compare of decoded keys, result register.
`timescale 1ns / 1ps
module bvc_back import bvc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  bvc_item_t   in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_bit
);
	logic valid_s2;
	logic res_s2;
	logic res_d, nan_side, eq, lt;
	bvc_val_t l, r;

	always_comb begin
		l = in_item.lv;
		r = in_item.rv;
		nan_side = l.nan || r.nan;
		eq = (l.zero && r.zero) || (l.neg == r.neg && l.mag == r.mag);
		if (l.neg != r.neg) lt = l.neg && !eq;
		else if (l.neg) lt = l.mag > r.mag;
		else lt = l.mag < r.mag;
		case (in_item.op)
			OP_EQ:     res_d = in_item.same || (!nan_side && eq);
			OP_NEQ:    res_d = !in_item.same && (nan_side || !eq);
			OP_LT:     res_d = !nan_side && lt;
			OP_LTE:    res_d = !nan_side && (lt || eq);
			OP_GT:     res_d = !nan_side && !lt && !eq;
			OP_GTE:    res_d = !nan_side && !lt;
			OP_TRUTHY: res_d = in_item.truth;
			default:   res_d = 1'b0;
		endcase
	end

	assign in_ready = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign result_bit = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (in_ready) valid_s2 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) res_s2 <= res_d;
	end

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s2 && $stable(res_s2))
		else $error("result beat changed while stalled");
	a_unused_false: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.op == OP_UNUSED |=> !res_s2)
		else $error("unused op gave true");
	a_nan_order: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.op == OP_LT && nan_side |=> !res_s2)
		else $error("ordered compare true with NaN side");
`endif
endmodule

>>> test/tb_boxed_value_compare_top.sv
// Self-checking testbench for boxed_value_compare_top: directed table, then random beats.
`timescale 1ns / 1ps
module tb_boxed_value_compare_top;
	import bvc_pkg::*;

	localparam logic [63:0] BOOL_TRUE_WORD = BOOL_FALSE_WORD | 64'd1;
	localparam logic [63:0] POS_ZERO = 64'h0000000000000000;
	localparam logic [63:0] NEG_ZERO = 64'h8000000000000000;
	localparam logic [63:0] POS_INF = 64'h7FF0000000000000;
	localparam logic [63:0] NEG_INF = 64'hFFF0000000000000;
	localparam logic [63:0] ONE_DBL = 64'h3FF0000000000000;
	localparam int N_RANDOM = 1500;

	typedef struct {
		logic [2:0]  op;
		logic [63:0] lw;
		logic [63:0] rw;
	} req_t;

	typedef struct {
		req_t req;
		bit   known;
		bit   want;
	} row_t;

	logic clk, arst_n, push, full, empty, pop, result_bit;
	logic [2:0] req_type;
	logic [63:0] left_word, right_word, result_word;

	bit outcome_q[$];
	int errors, n_sent, n_checked, n_true;
	bit stim_done;
	row_t rows[$];

	boxed_value_compare_top DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.req_type(req_type), .left_word(left_word), .right_word(right_word),
		.empty(empty), .pop(pop), .result_bit(result_bit), .result_word(result_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [63:0] box(input logic [2:0] tag, input logic [47:0] pl);
		return QNAN_PREFIX | {13'd0, tag, pl};
	endfunction

	// decode a boxed word; nan flag is taken from the bits, not from real compares
	function automatic void unbox(input logic [63:0] w, output real v, output bit nan);
		logic signed [47:0] i48;
		v = 0.0;
		nan = 1'b0;
		if (w[62:51] != 12'hFFF) begin
			nan = (w[62:52] == 11'h7FF) && (w[51:0] != 0);
			if (!nan) v = $bitstoreal(w);
		end else if (w[50:48] == TAG_INT48) begin
			i48 = w[47:0];
			v = real'(i48);
		end else if (w[50:48] == TAG_BOOL) begin
			v = (w[47:0] != 0) ? 1.0 : 0.0;
		end else begin
			nan = 1'b1;
		end
	endfunction

	function automatic bit compare_outcome(input req_t r);
		real lv, rv;
		bit ln, rn, any_nan;
		unbox(r.lw, lv, ln);
		unbox(r.rw, rv, rn);
		any_nan = ln | rn;
		case (r.op)
			OP_EQ:  return (r.lw == r.rw) ? 1'b1 : (!any_nan && lv == rv);
			OP_NEQ: return (r.lw == r.rw) ? 1'b0 : (any_nan || lv != rv);
			OP_LT:  return !any_nan && lv < rv;
			OP_LTE: return !any_nan && lv <= rv;
			OP_GT:  return !any_nan && lv > rv;
			OP_GTE: return !any_nan && lv >= rv;
			OP_TRUTHY: begin
				if (r.lw == NULL_WORD) return 1'b0;
				if (r.lw[62:51] != 12'hFFF) return !ln && (r.lw[62:0] != 0);
				if (r.lw[50:48] == TAG_INT48 || r.lw[50:48] == TAG_BOOL)
					return r.lw[47:0] != 0;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [63:0] rand_word();
		logic [63:0] w;
		int sv;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: ;
			1: w = box(TAG_INT48, {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
				16'(16'($urandom_range(0, 7)) - 16'd3), w[15:0] & 16'h0003});
			2: w = box(TAG_INT48, w[47:0]) | {w[63], 63'd0};
			3: w = box(TAG_BOOL, $urandom_range(0, 1) ? 48'd0 : w[47:0]);
			4: w = $urandom_range(0, 1) ? NULL_WORD : box(3'($urandom_range(0, 7)), w[47:0]);
			5: begin
				sv = $urandom_range(0, 8) - 4;
				w = $bitstoreal(0) == 0.0 ? $realtobits(real'(sv)) : w;
			end
			6: case ($urandom_range(0, 4))
				0: w = POS_ZERO;
				1: w = NEG_ZERO;
				2: w = POS_INF;
				3: w = NEG_INF;
				default: w = {w[63], 11'h7FF, 1'b0, w[50:0] | 51'd1};
			endcase
			7: w = {w[63], 11'h3FF + 11'($urandom_range(0, 4)) - 11'd2, w[51:0]};
			default: w = {w[63:52], 52'd0};
		endcase
		return w;
	endfunction

	function automatic row_t mk(input logic [2:0] op, input logic [63:0] l,
			input logic [63:0] r, input bit known, input bit want);
		row_t x;
		x.req.op = op;
		x.req.lw = l;
		x.req.rw = r;
		x.known = known;
		x.want = want;
		return x;
	endfunction

	function automatic void add_row(input logic [2:0] op, input logic [63:0] l,
			input logic [63:0] r, input bit known, input bit want);
		rows = {rows, mk(op, l, r, known, want)};
	endfunction

	// request side
	initial begin
		req_t r;
		int gap;
		push = 1'b0;
		req_type = OP_EQ;
		left_word = '0;
		right_word = '0;
		arst_n = 1'b0;
		stim_done = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		add_row(OP_EQ, NULL_WORD, NULL_WORD, 1, 1);
		add_row(OP_NEQ, box(3'd5, 48'd7), box(3'd5, 48'd7), 1, 0);
		add_row(OP_EQ, box(3'd5, 48'd7), box(3'd5, 48'd8), 1, 0);
		add_row(OP_NEQ, NULL_WORD, ONE_DBL, 1, 1);
		add_row(OP_EQ, box(TAG_INT48, 48'd1), ONE_DBL, 1, 1);
		add_row(OP_EQ, POS_ZERO, NEG_ZERO, 1, 1);
		add_row(OP_LT, box(TAG_INT48, 48'h800000000000),
			box(TAG_INT48, 48'h7FFFFFFFFFFF), 1, 1);
		add_row(OP_LTE, POS_INF, NEG_INF, 1, 0);
		add_row(OP_GT, ONE_DBL, box(TAG_BOOL, 48'd0), 1, 1);
		add_row(OP_GTE, NULL_WORD, NULL_WORD, 1, 0);
		add_row(OP_LT, 64'hFFFFFFFFFFFFFFFF, ONE_DBL, 1, 0);
		add_row(OP_GTE, box(TAG_BOOL, 48'hFFFFFFFFFFFF), ONE_DBL, 1, 1);
		add_row(OP_TRUTHY, NULL_WORD, 64'hFFFFFFFFFFFFFFFF, 1, 0);
		add_row(OP_TRUTHY, NULL_WORD | 64'd1, '0, 1, 1);
		add_row(OP_TRUTHY, NEG_ZERO, '0, 1, 0);
		add_row(OP_TRUTHY, 64'h7FF0000000000001, '0, 1, 0);
		add_row(OP_TRUTHY, box(TAG_INT48, 48'd0), '0, 1, 0);
		add_row(OP_TRUTHY, box(TAG_BOOL, 48'd2), '0, 1, 1);
		add_row(OP_TRUTHY, box(3'd7, 48'd0), '0, 1, 1);
		add_row(OP_TRUTHY, POS_INF, '0, 1, 1);
		add_row(OP_UNUSED, NULL_WORD, NULL_WORD, 1, 0);
		add_row(OP_UNUSED, 64'hFFFFFFFFFFFFFFFF, 64'h0, 1, 0);
		add_row(OP_LTE, box(TAG_INT48, 48'hFFFFFFFFFFFF),
			$realtobits(-1.0), 0, 0);
		add_row(OP_GT, 64'h8000000000000001, POS_ZERO, 0, 0);

		for (int i = 0; i < rows.size() + N_RANDOM; i++) begin
			if (i < rows.size()) begin
				r = rows[i].req;
				if (rows[i].known && compare_outcome(r) != rows[i].want) begin
					$error("table row %0d: predictor gives %0b, table %0b",
						i, compare_outcome(r), rows[i].want);
					errors++;
				end
			end else begin
				r.op = 3'($urandom_range(0, 7));
				r.lw = rand_word();
				case ($urandom_range(0, 3))
					0: r.rw = r.lw;
					1: r.rw = r.lw ^ (64'd1 << $urandom_range(0, 63));
					default: r.rw = rand_word();
				endcase
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			push <= 1'b1;
			req_type <= r.op;
			left_word <= r.lw;
			right_word <= r.rw;
			@(posedge clk);
			while (full) @(posedge clk);
			outcome_q = {outcome_q, compare_outcome(r)};
			n_sent++;
		end
		push <= 1'b0;
		stim_done = 1'b1;
	end

	// result side
	initial begin
		bit want;
		int gap;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			n_checked++;
			if (outcome_q.size() == 0) begin
				$error("result beat with nothing expected: bit %0b word %h",
					result_bit, result_word);
				errors++;
			end else begin
				want = outcome_q.pop_front();
				n_true += want;
				if (result_bit !== want) begin
					$error("result_bit: expected %0b, got %0b", want, result_bit);
					errors++;
				end
				if (result_word !== (want ? BOOL_TRUE_WORD : BOOL_FALSE_WORD)) begin
					$error("result_word: expected %h, got %h",
						want ? BOOL_TRUE_WORD : BOOL_FALSE_WORD, result_word);
					errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_true = 0;
		@(posedge arst_n);
		wait (stim_done);
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (!empty) begin
			$error("block still holds a result after all expected beats");
			errors++;
		end
		$display("%0d request beats sent, %0d result beats checked (%0d true)",
			n_sent, n_checked, n_true);
		$display("covered all compare ops, truthiness and the unused selector");
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
